// File: sv/ccrc_pkg.sv
// Package for the configurable CRC engine.
// Holds the register indexes, width codes, reset values and the config bundle.
// No dependencies; every other file imports it.
package ccrc_pkg;

  localparam int unsigned CRC_W             = 32;
  localparam int unsigned MAX_CRC_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned WSEL_W            = 2;

  localparam logic [WSEL_W-1:0] WSEL_RESET   = 2'd2;
  localparam logic [CRC_W-1:0]  POLY_RESET   = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0]  START_RESET  = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]  OXOR_RESET   = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_SELECT   = 3'd0,
    REG_GENERATOR_POLY = 3'd1,
    REG_START_VALUE    = 3'd2,
    REG_OUTPUT_XOR     = 3'd3,
    REG_REFLECT_INPUT  = 3'd4,
    REG_REFLECT_OUTPUT = 3'd5
  } cfg_reg_e;

  typedef enum logic [WSEL_W-1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2
  } width_sel_e;

  typedef struct packed {
    logic [WSEL_W-1:0] width_sel;
    logic [CRC_W-1:0]  poly;
    logic [CRC_W-1:0]  start;
    logic [CRC_W-1:0]  oxor;
    logic              refl_in;
    logic              refl_out;
  } cfg_t;

endpackage

// File: sv/ccrc_cfg.sv
// Configuration register file of the CRC engine.
// Depends on ccrc_pkg for register indexes, reset values and cfg_t.
module ccrc_cfg import ccrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CRC_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH_SELECT:   cfg_d.width_sel = cfg_wdata_i[WSEL_W-1:0];
        REG_GENERATOR_POLY: cfg_d.poly      = cfg_wdata_i;
        REG_START_VALUE:    cfg_d.start     = cfg_wdata_i;
        REG_OUTPUT_XOR:     cfg_d.oxor      = cfg_wdata_i;
        REG_REFLECT_INPUT:  cfg_d.refl_in   = cfg_wdata_i[0];
        REG_REFLECT_OUTPUT: cfg_d.refl_out  = cfg_wdata_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_sel <= WSEL_RESET;
      cfg_q.poly      <= POLY_RESET;
      cfg_q.start     <= START_RESET;
      cfg_q.oxor      <= OXOR_RESET;
      cfg_q.refl_in   <= 1'b1;
      cfg_q.refl_out  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/ccrc_update.sv
// One-byte CRC update and checksum finishing logic, purely combinational.
// Depends on ccrc_pkg for cfg_t, width codes and CRC_W.
module ccrc_update import ccrc_pkg::*; #(
  parameter int unsigned MaxW = MAX_CRC_WIDTH_DEF
) (
  input  cfg_t              cfg_i,
  input  logic              start_i,
  input  logic [MaxW-1:0]   acc_i,
  input  logic [7:0]        data_i,
  output logic [MaxW-1:0]   acc_o,
  output logic [CRC_W-1:0]  chk_o
);

  localparam int unsigned WW = $clog2(MaxW + 1);
  localparam int unsigned IW = $clog2(MaxW);

  logic [5:0]      raw_w;
  logic [WW-1:0]   w;
  logic [MaxW-1:0] mask;
  logic [MaxW-1:0] poly;
  logic [IW-1:0]   top;
  logic [WW-1:0]   byte_sh;
  logic [7:0]      data_r;
  logic [MaxW-1:0] crc;
  logic [MaxW-1:0] crc_rev;
  logic [MaxW-1:0] fin;

  always_comb begin
    case (width_sel_e'(cfg_i.width_sel))
      WSEL_8:  raw_w = 6'd8;
      WSEL_16: raw_w = 6'd16;
      WSEL_32: raw_w = 6'd32;
      default: raw_w = 6'd32;
    endcase
    w = (raw_w > 6'(MaxW)) ? WW'(MaxW) : WW'(raw_w);
  end

  always_comb begin
    for (int i = 0; i < MaxW; i++) begin
      mask[i] = (WW'(i) < w);
    end
  end

  assign poly    = cfg_i.poly[MaxW-1:0] & mask;
  assign top     = IW'(w - WW'(1));
  assign byte_sh = w - WW'(8);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_r[i] = cfg_i.refl_in ? data_i[7-i] : data_i[i];
    end
  end

  // Direct (non-augmenting) update, eight shift/XOR steps.
  always_comb begin
    logic fb;
    fb  = 1'b0;
    crc = (start_i ? cfg_i.start[MaxW-1:0] : acc_i) & mask;
    crc = crc ^ (MaxW'(data_r) << byte_sh);
    for (int k = 0; k < 8; k++) begin
      fb  = crc[top];
      crc = (crc << 1) & mask;
      if (fb) begin
        crc = crc ^ poly;
      end
    end
  end

  assign acc_o = crc;

  // Reverse over the full register, then realign to the selected width.
  always_comb begin
    for (int i = 0; i < MaxW; i++) begin
      crc_rev[i] = crc[MaxW-1-i];
    end
  end

  assign fin   = ((cfg_i.refl_out ? (crc_rev >> (WW'(MaxW) - w)) : crc)
                  ^ cfg_i.oxor[MaxW-1:0]) & mask;
  assign chk_o = CRC_W'(fin);

endmodule

// File: sv/configurable_crc_engine_top.sv
// Configurable CRC engine, byte-wide, parameterized width/poly/init/xor/reflection.
// Output: the checksum is registered when the last byte of a message leaves the input register.
// Throughput: one byte per cycle unless a last byte waits on a stalled checksum; the one-byte
// update between the input register and the accumulator register sets that figure.
// Reset: asynchronous, active low; clears both pipeline valids, the message
// state and the accumulator, and loads the configuration defaults.
module configurable_crc_engine_top import ccrc_pkg::*; #(
  parameter int unsigned MAX_CRC_WIDTH = MAX_CRC_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CRC_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [CRC_W-1:0]     m_axis_tdata    // [31:0] checksum
);

  cfg_t                   cfg;
  logic                   in_vld_q;
  logic [7:0]             in_data_q;
  logic                   in_last_q;
  logic                   mid_q;
  logic [MAX_CRC_WIDTH-1:0] acc_q;
  logic [MAX_CRC_WIDTH-1:0] acc_d;
  logic [CRC_W-1:0]       chk_d;
  logic                   out_vld_q;
  logic [CRC_W-1:0]       out_data_q;
  logic                   out_free;
  logic                   consume;
  logic                   in_take;

  ccrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ccrc_update #(.MaxW(MAX_CRC_WIDTH)) u_update (
    .cfg_i   (cfg),
    .start_i (!mid_q),
    .acc_i   (acc_q),
    .data_i  (in_data_q),
    .acc_o   (acc_d),
    .chk_o   (chk_d)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign consume       = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_vld_q || consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mid_q     <= 1'b0;
      acc_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (consume) begin
        acc_q <= acc_d;
        mid_q <= !in_last_q;
      end
      if (consume && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (consume && in_last_q) begin
      out_data_q <= chk_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/ccrc_checker.sv
// Port-level checker for the CRC engine top level, attached by bind.
// Depends on ccrc_pkg and on the port list of configurable_crc_engine_top.
module ccrc_checker import ccrc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [CRC_W-1:0]     m_axis_tdata
);

  // A stalled checksum request holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("checksum request dropped or changed while stalled");

  // Input back-pressure only comes from a stalled finished checksum.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending checksum");

  // No checksum is presented right out of reset.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("checksum valid right after reset");

endmodule

bind configurable_crc_engine_top ccrc_checker u_ccrc_checker (.*);
